/* rtl/adsr_pkg.sv */
// Shared types, constants and the sine table builder for the ADSR sine tone generator.
// No dependencies; used by adsr_ctrl, adsr_dp and adsr_sine_tone_generator.
`default_nettype none

package adsr_pkg;

	// Sine table geometry. The entry count is a power of two.
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_AW      = $clog2(SINE_ENTRIES);
	localparam int SINE_QUARTER = SINE_ENTRIES / 4;
	localparam int SINE_QW      = SINE_AW - 2;

	// Note length limits.
	localparam logic [15:0] MAX_DURATION_MS = 16'd16383;
	localparam logic [19:0] TOTAL_MAX       = 20'hFFFFF;
	localparam logic [5:0]  SAMPLES_PER_MS  = 6'd44;

	// Phase step = freq_q4 * 2^32 / (16 * 44100) = freq_q4 * 2^26 / 11025.
	// The estimate (freq_q4 * STEP_RECIP) >> STEP_RECIP_SHIFT is exact or one below.
	localparam logic [15:0] STEP_ODD_DIV     = 16'd11025;
	localparam logic [31:0] STEP_RECIP       = 32'((64'd1 << 45) / 64'd11025);
	localparam int          STEP_RECIP_SHIFT = 19;

	// Divider step count: 15 quotient bits for the envelope position.
	localparam int          DIV_CNT_W   = 6;
	localparam logic [5:0]  ENV_STEPS   = 6'd15;

	// Envelope constants in Q15.
	localparam logic [16:0] ENV_DECAY_BASE = 17'd33587;
	localparam logic [14:0] ENV_SUSTAIN    = 15'd29491;
	localparam logic [16:0] ENV_ONE        = 17'd32768;

	// Configuration register indexes.
	localparam logic REG_AMPLITUDE = 1'b0;

	localparam logic [14:0] AMP_RESET = 15'd32767;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [14:0] sine_tab_t [0:SINE_QUARTER];

	// Controller to datapath commands.
	typedef struct packed {
		logic start_note;
		logic start_tick;
		logic div_step;
		logic step_fix;
		logic set_step;
		logic env_calc;
		logic mul_amp;
		logic mul_sine;
		logic emit_tone;
		logic emit_silent;
	} adsr_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic active;
		logic div_last;
	} adsr_stat_t;

	// Quarter-wave sine table: Taylor series to the t^13 term in Q2.30, scaled to Q15.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int k = 0; k <= SINE_QUARTER; k++) begin
			t    = (HALF_PI_Q30 * 64'(k)) / SINE_QUARTER;
			term = t;
			sum  = t;
			for (int n = 1; n <= 6; n++) begin
				term = (term * t) >> 30;
				term = (term * t) >> 30;
				case (n)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					default: term = term / 64'd156;
				endcase
				if (n[0]) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			tab[k] = v[14:0];
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

/* rtl/adsr_ctrl.sv */
// Sequencing state machine of the ADSR sine tone generator.
// Uses adsr_pkg; drives the datapath adsr_dp through command and status structs.
`default_nettype none

module adsr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                operation,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire adsr_pkg::adsr_stat_t stat,
	output adsr_pkg::adsr_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIX,
		ST_DIV,
		ST_STEP,
		ST_ENV,
		ST_MUL_AMP,
		ST_MUL_SINE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   silent_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.start_note  = accept && operation;
		cmd.start_tick  = accept && !operation && stat.active;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.step_fix    = (state_q == ST_FIX);
		cmd.set_step    = (state_q == ST_STEP);
		cmd.env_calc    = (state_q == ST_ENV);
		cmd.mul_amp     = (state_q == ST_MUL_AMP);
		cmd.mul_sine    = (state_q == ST_MUL_SINE);
		cmd.emit_tone   = (state_q == ST_EMIT) && slot_free && !silent_q;
		cmd.emit_silent = (state_q == ST_EMIT) && slot_free && silent_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			silent_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_tone || cmd.emit_silent) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						silent_q <= !operation && !stat.active;
						if (operation) begin
							state_q <= ST_FIX;
						end else if (stat.active) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_FIX:      state_q <= ST_STEP;
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_ENV;
					end
				end
				ST_STEP:     state_q <= ST_IDLE;
				ST_ENV:      state_q <= ST_MUL_AMP;
				ST_MUL_AMP:  state_q <= ST_MUL_SINE;
				ST_MUL_SINE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/adsr_dp.sv */
// Datapath of the ADSR sine tone generator: note state, serial divider, envelope,
// sine table and the two multiply steps. Uses adsr_pkg; driven by adsr_ctrl.
`default_nettype none

module adsr_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [14:0]          amplitude,
	input  wire logic [18:0]          freq_q4,
	input  wire logic [13:0]          duration_ms,
	input  wire adsr_pkg::adsr_cmd_t  cmd,
	output adsr_pkg::adsr_stat_t      stat,
	output logic signed [15:0]        sample,
	output logic                      playing
);

	localparam adsr_pkg::sine_tab_t SINE_TAB = adsr_pkg::build_sine_tab();

	logic [31:0] phase_acc_q;
	logic [31:0] phase_step_q;
	logic [19:0] sample_index_q;
	logic [19:0] sample_total_q;

	logic [19:0]                   rem_q;
	logic [31:0]                   quot_q;
	logic [adsr_pkg::DIV_CNT_W-1:0] cnt_q;

	logic [14:0]        env_q;
	logic signed [15:0] sine_q;
	logic [29:0]        amp_env_q;
	logic signed [46:0] prod_q;
	logic signed [15:0] sample_q;
	logic               playing_q;

	// Note length in samples, with clamping and saturation.
	logic [15:0] dur_clamped;
	logic [21:0] total_wide;
	logic [19:0] total_sat;

	// Phase step by reciprocal multiplication. The remainder of the estimate is below
	// twice the divisor, so its low 16 bits are enough to decide the correction.
	logic [50:0] step_prod;
	logic [15:0] step_rem;

	// Divider step.
	logic [19:0] divisor;
	logic [20:0] rem_shift;
	logic [20:0] rem_diff;
	logic        q_bit;

	// Envelope and table lookup.
	logic [14:0]              x;
	logic [20:0]              x40;
	logic [17:0]              x8;
	logic [18:0]              x10;
	logic [16:0]              env_wide;
	logic [adsr_pkg::SINE_AW-1:0] tab_idx;
	logic [1:0]               quad;
	logic [adsr_pkg::SINE_QW-1:0] tab_pos;
	logic [adsr_pkg::SINE_QW:0]   tab_addr;
	logic [14:0]              tab_val;

	assign dur_clamped = ({2'b00, duration_ms} > adsr_pkg::MAX_DURATION_MS)
		? adsr_pkg::MAX_DURATION_MS : {2'b00, duration_ms};
	assign total_wide  = 22'(dur_clamped * 22'(adsr_pkg::SAMPLES_PER_MS));
	assign total_sat   = (total_wide > 22'(adsr_pkg::TOTAL_MAX))
		? adsr_pkg::TOTAL_MAX : total_wide[19:0];

	assign step_prod = 51'(freq_q4) * 51'(adsr_pkg::STEP_RECIP);
	assign step_rem  = 16'd0 - quot_q[15:0] * adsr_pkg::STEP_ODD_DIV;

	assign divisor   = sample_total_q;
	assign rem_shift = {rem_q, 1'b0};
	assign rem_diff  = rem_shift - {1'b0, divisor};
	assign q_bit     = (rem_shift >= {1'b0, divisor});

	assign stat.active   = (sample_index_q < sample_total_q);
	assign stat.div_last = (cnt_q == adsr_pkg::DIV_CNT_W'(1));

	always_comb begin
		x   = quot_q[14:0];
		x40 = 21'(x) * 21'd40;
		x8  = {x, 3'b000};
		x10 = 19'(x) * 19'd10;
		if (x40 < 21'd32768) begin
			env_wide = x40[16:0];
		end else if (x8 < 18'd32768) begin
			env_wide = adsr_pkg::ENV_DECAY_BASE - 17'(x);
		end else if (x10 < 19'd229376) begin
			env_wide = 17'(adsr_pkg::ENV_SUSTAIN);
		end else begin
			env_wide = 17'(17'd3 * (adsr_pkg::ENV_ONE - 17'(x)));
		end
	end

	assign tab_idx  = phase_acc_q[31 -: adsr_pkg::SINE_AW];
	assign quad     = tab_idx[adsr_pkg::SINE_AW-1 -: 2];
	assign tab_pos  = tab_idx[adsr_pkg::SINE_QW-1:0];
	assign tab_addr = quad[0]
		? (adsr_pkg::SINE_QW+1)'(adsr_pkg::SINE_QUARTER) - {1'b0, tab_pos}
		: {1'b0, tab_pos};
	assign tab_val  = SINE_TAB[tab_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q    <= '0;
			phase_step_q   <= '0;
			sample_index_q <= '0;
			sample_total_q <= '0;
			cnt_q          <= '0;
		end else begin
			if (cmd.start_note) begin
				phase_acc_q    <= '0;
				sample_index_q <= '0;
				sample_total_q <= total_sat;
			end else if (cmd.start_tick) begin
				cnt_q <= adsr_pkg::ENV_STEPS;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - adsr_pkg::DIV_CNT_W'(1);
			end
			if (cmd.set_step) begin
				phase_step_q <= (rem_q[15:0] >= adsr_pkg::STEP_ODD_DIV)
					? quot_q + 32'd1 : quot_q;
			end
			if (cmd.emit_tone) begin
				phase_acc_q    <= phase_acc_q + phase_step_q;
				sample_index_q <= sample_index_q + 20'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_note) begin
			quot_q <= step_prod[adsr_pkg::STEP_RECIP_SHIFT +: 32];
		end else if (cmd.start_tick) begin
			rem_q <= sample_index_q;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? rem_diff[19:0] : rem_shift[19:0];
			quot_q <= {quot_q[30:0], q_bit};
		end
		if (cmd.step_fix) begin
			rem_q <= {4'd0, step_rem};
		end
		if (cmd.env_calc) begin
			env_q  <= env_wide[14:0];
			sine_q <= quad[1] ? -$signed({1'b0, tab_val}) : $signed({1'b0, tab_val});
		end
		if (cmd.mul_amp) begin
			amp_env_q <= 30'(amplitude) * 30'(env_q);
		end
		if (cmd.mul_sine) begin
			prod_q <= 47'($signed({1'b0, amp_env_q})) * 47'(sine_q);
		end
		if (cmd.emit_tone) begin
			sample_q  <= prod_q[45:30];
			playing_q <= 1'b1;
		end else if (cmd.emit_silent) begin
			sample_q  <= '0;
			playing_q <= 1'b0;
		end
	end

	assign sample  = sample_q;
	assign playing = playing_q;

endmodule

`default_nettype wire

/* rtl/adsr_sine_tone_generator.sv */
// Top level of the ADSR sine tone generator: configuration port, controller and datapath.
// Uses adsr_pkg, adsr_ctrl and adsr_dp.
//
//   Channel   Handshake           Payload
//   in        in_valid/in_ready   operation, freq_q4, duration_ms
//   out       out_valid/out_ready sample, playing
//   config    APB psel/penable    paddr, pwdata, prdata (amplitude at byte address 0)
//
// A tick item that falls inside a note runs the restoring divider, which forms the
// 15-bit envelope position one quotient bit per cycle, followed by envelope/table,
// the amplitude and sine multiplies and the output load before the block is ready
// again. A tick after the note end goes straight to the output load. A start-note
// item estimates the phase step by a reciprocal multiply at acceptance, the next
// cycle forms its remainder, and ST_STEP then loads the corrected step.
// Reset clears the note state, so every tick is silent until a note is started.
// A finished sample waits in the output register; the block accepts the next item
// meanwhile and stalls only when a new sample must be loaded into a full register.
`default_nettype none

module adsr_sine_tone_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [18:0]        freq_q4,
	input  wire logic [13:0]        duration_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      sample,
	output logic                    playing,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	adsr_pkg::adsr_cmd_t  cmd;
	adsr_pkg::adsr_stat_t stat;

	logic [14:0] amplitude_q;
	logic        reg_wr;

	// The register index is the word address; the two low address bits are ignored.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= adsr_pkg::AMP_RESET;
		end else if (reg_wr && (paddr[2] == adsr_pkg::REG_AMPLITUDE)) begin
			amplitude_q <= pwdata[14:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			adsr_pkg::REG_AMPLITUDE: prdata = {17'd0, amplitude_q};
			default:                 prdata = '0;
		endcase
	end

	// The controller sequences one item at a time and owns both handshakes.
	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the note state and computes each sample.
	adsr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.amplitude   (amplitude_q),
		.freq_q4     (freq_q4),
		.duration_ms (duration_ms),
		.cmd         (cmd),
		.stat        (stat),
		.sample      (sample),
		.playing     (playing)
	);

	// A silent item always carries a zero sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !playing) |-> (sample == 16'sd0))
		else $error("silent item with nonzero sample");

	// Every accepted item makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// An amplitude write lands in the register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(reg_wr && (paddr[2] == adsr_pkg::REG_AMPLITUDE)) |=> (amplitude_q == $past(pwdata[14:0])))
		else $error("amplitude write lost");

endmodule

`default_nettype wire
